@@ hdl/pcf_pkg.sv @@
// Shared types, constants and CRC-32 helpers for the PNG chunk framer.
// Used by pcf_build, pcf_serial and png_chunk_framer_crc32_top; no dependencies.
package pcf_pkg;

  localparam int MaxItems = 12;
  localparam int CountW   = $clog2(MaxItems + 1);
  localparam int IdxW     = $clog2(MaxItems);
  localparam int LenW     = 31;

  localparam logic        KIND_START = 1'b0;
  localparam logic        KIND_DATA  = 1'b1;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic            kind;
    logic [LenW-1:0] chunk_length;
    logic [31:0]     chunk_type;
    logic [7:0]      data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       chunk_done;
    logic       error;
  } out_t;

  typedef struct packed {
    out_t [MaxItems-1:0] items;
    logic [CountW-1:0]   count;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } pend_t;

  typedef logic [255:0][31:0] crc_table_t;

  function automatic crc_table_t crc_make_table();
    crc_table_t  tbl;
    logic [31:0] c;
    for (int n = 0; n < 256; n++) begin
      c = 32'(n);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tbl[n] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_make_table();

  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
  endfunction

endpackage

@@ hdl/pcf_build.sv @@
// Frame builder: holds the CRC and chunk state and turns one accepted item
// into a descriptor of up to twelve result items. Depends on pcf_pkg.
module pcf_build import pcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_fire,
  input  in_t   req,
  input  logic  load,
  output pend_t pend
);

  logic [31:0]     crc;
  logic [LenW-1:0] bytes_left;
  logic            chunk_open;
  logic [31:0]     crc_next;
  logic [LenW-1:0] bytes_left_next;
  logic            chunk_open_next;
  desc_t           desc_next;
  logic [31:0]     type_crc;
  logic [31:0]     data_crc;
  logic [31:0]     fin;
  logic [LenW-1:0] left_dec;
  logic [31:0]     len_word;

  always_comb begin
    type_crc = CRC_SEED;
    for (int i = 0; i < 4; i++) begin
      type_crc = crc_fold(type_crc, req.chunk_type[8*(3-i) +: 8]);
    end
    data_crc = crc_fold(crc, req.data_byte);
    left_dec = bytes_left - LenW'(1);
    len_word = {1'b0, req.chunk_length};
  end

  always_comb begin
    desc_next       = '0;
    crc_next        = crc;
    bytes_left_next = bytes_left;
    chunk_open_next = chunk_open;
    fin             = '0;
    if (req.kind == KIND_START) begin
      for (int i = 0; i < 4; i++) begin
        desc_next.items[i].out_byte   = len_word[8*(3-i) +: 8];
        desc_next.items[i+4].out_byte = req.chunk_type[8*(3-i) +: 8];
      end
      crc_next        = type_crc;
      bytes_left_next = req.chunk_length;
      if (req.chunk_length != '0) begin
        desc_next.items[7].end_of_run = 1'b1;
        desc_next.count               = CountW'(8);
        chunk_open_next               = 1'b1;
      end else begin
        fin = type_crc ^ CRC_SEED;
        for (int i = 0; i < 4; i++) begin
          desc_next.items[i+8].out_byte = fin[8*(3-i) +: 8];
        end
        desc_next.items[11].end_of_run = 1'b1;
        desc_next.items[11].chunk_done = 1'b1;
        desc_next.count                = CountW'(12);
        chunk_open_next                = 1'b0;
      end
    end else if (!chunk_open) begin
      desc_next.items[0].end_of_run = 1'b1;
      desc_next.items[0].error      = 1'b1;
      desc_next.count               = CountW'(1);
    end else begin
      crc_next                      = data_crc;
      bytes_left_next               = left_dec;
      desc_next.items[0].out_byte   = req.data_byte;
      desc_next.items[0].end_of_run = (left_dec != '0);
      if (left_dec != '0) begin
        desc_next.count = CountW'(1);
      end else begin
        fin = data_crc ^ CRC_SEED;
        for (int i = 0; i < 4; i++) begin
          desc_next.items[i+1].out_byte = fin[8*(3-i) +: 8];
        end
        desc_next.items[4].end_of_run = 1'b1;
        desc_next.items[4].chunk_done = 1'b1;
        desc_next.count               = CountW'(5);
        chunk_open_next               = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_SEED;
      bytes_left <= '0;
      chunk_open <= 1'b0;
      pend.valid <= 1'b0;
    end else begin
      if (req_fire) begin
        crc        <= crc_next;
        bytes_left <= bytes_left_next;
        chunk_open <= chunk_open_next;
        pend.valid <= 1'b1;
      end else if (load) begin
        pend.valid <= 1'b0;
      end
    end
    if (req_fire) begin
      pend.desc <= desc_next;
    end
  end

endmodule

@@ hdl/pcf_serial.sv @@
// Result serializer: takes a descriptor from the builder and presents its
// items on rsp, one per cycle while rsp_ready is high. Depends on pcf_pkg.
module pcf_serial import pcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  pend_t pend,
  output logic  load,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output out_t  rsp
);

  desc_t           cur;
  logic            cur_valid;
  logic [IdxW-1:0] idx;
  logic            cur_last;
  logic            take;

  always_comb begin
    cur_last  = (CountW'(idx) == CountW'(cur.count - CountW'(1)));
    take      = !cur_valid || (rsp_ready && cur_last);
    load      = pend.valid && take;
    rsp_valid = cur_valid;
    rsp       = cur.items[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_valid && rsp_ready) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pend.desc;
    end
  end

endmodule

@@ hdl/png_chunk_framer_crc32_top.sv @@
// Top level of the PNG chunk framer with CRC-32.
// Depends on pcf_pkg, pcf_build and pcf_serial.
//
//   Channel  Handshake              Payload  Moves
//   req      req_valid/req_ready    in_t     one start or data item
//   rsp      rsp_valid/rsp_ready    out_t    one framed byte per item
//
// An accepted item is registered in pend and, with the serializer free, is moved
// into the serializer, which presents its results one per cycle while rsp_ready
// is high: 8 for a start, 12 for a zero-length start, 1 for a data byte, 5 for a
// chunk's last. A held descriptor moves to the serializer on the edge that takes
// the previous last result, so single-result items flow at one per cycle while
// rsp_ready is high. A stalled rsp_ready holds the current result and, once the
// holding register is full, holds off req_ready. Reset is synchronous on rst.
module png_chunk_framer_crc32_top import pcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  in_t  req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output out_t rsp
);

  pend_t pend;
  logic  load;
  logic  req_fire;

  assign req_ready = !pend.valid || load;
  assign req_fire  = req_valid && req_ready;

  pcf_build u_build (
    .clk      (clk),
    .rst      (rst),
    .req_fire (req_fire),
    .req      (req),
    .load     (load),
    .pend     (pend)
  );

  pcf_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .pend      (pend),
    .load      (load),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_err_ends_run : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error |-> rsp.end_of_run && !rsp.chunk_done)
    else $error("error result does not end its run");

  a_done_ends_run : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.chunk_done |-> rsp.end_of_run)
    else $error("final CRC byte does not end its run");

  a_accept_held : assert property (@(posedge clk) disable iff (rst)
    req_fire |=> pend.valid)
    else $error("accepted item lost before holding register");

  a_load_fills : assert property (@(posedge clk) disable iff (rst)
    load |=> rsp_valid)
    else $error("descriptor load did not present a result");

endmodule
